[design/lca_pkg.sv]
// lca_pkg: shared types and constants for the binary-lifting common-ancestor engine
// request and response payload structs, mode and status codes, depth encodings
// no dependencies
`default_nettype none

package lca_pkg;

   localparam int NODE_W  = 10;
   localparam int DEPTH_W = 11;
   localparam int MODE_W  = 2;
   localparam int STAT_W  = 2;

   // depth encodings
   localparam logic [DEPTH_W-1:0] DEPTH_NONE = 11'h7ff;
   localparam logic [DEPTH_W-1:0] DEPTH_FULL = 11'h7fe;
   localparam logic [DEPTH_W-1:0] DEPTH_ROOT = 11'h001;

   // mode codes
   localparam logic [MODE_W-1:0] MODE_ROOT  = 2'd0;
   localparam logic [MODE_W-1:0] MODE_EDGE  = 2'd1;
   localparam logic [MODE_W-1:0] MODE_QUERY = 2'd2;

   // status codes
   localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
   localparam logic [STAT_W-1:0] ST_REJECT    = 2'd1;
   localparam logic [STAT_W-1:0] ST_UNPLACED  = 2'd2;

   typedef struct packed {
      logic [MODE_W-1:0] mode;
      logic [NODE_W-1:0] node_a;
      logic [NODE_W-1:0] node_b;
   } lca_req_type;

   typedef struct packed {
      logic [NODE_W-1:0] ancestor;
      logic [STAT_W-1:0] status;
   } lca_rsp_type;

endpackage

`default_nettype wire

[design/lca_binary_lifting_engine.sv]
// lca_binary_lifting_engine: depth table, binary-lifting ancestor table and query sequencer
// depends on lca_pkg for payload structs, mode/status codes and depth encodings
// holds both tables as on-chip memories inside this module
//
// Usage:
//   req channel (req_valid/req_ready/req_data) carries one command per transaction:
//   set root, add edge (parent must already be placed) or common-ancestor query.
//   rsp channel (rsp_valid/rsp_ready/rsp_data) returns exactly one result per
//   command, in order: the ancestor (queries only, else zero) and a status code.
//   One command is in flight at a time; req_ready is high only while the sequencer
//   is idle. From acceptance to the result register, the sequencer performs:
//     set root / add edge : one ancestor-table write per level
//     query               : depth lift, then paired lift
//     rejected or unknown : the depth reads and the check only
//   The sequencer then returns to S_IDLE before the next transaction is taken. The
//   single read port of the depth table and the ancestor-table ports, one level per cycle,
//   pace these steps. After reset the depth table is swept one entry per cycle, during
//   which req_ready stays low. A finished result sits in the output register while
//   the next command is accepted and worked on; if rsp_ready is still low when that
//   command finishes, the sequencer holds its result until the register drains.
`default_nettype none

module lca_binary_lifting_engine
   import lca_pkg::*;
#(
   parameter int NODES  = 1024,
   parameter int LEVELS = 10
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire lca_req_type req_data,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output lca_rsp_type      rsp_data
);

   localparam int AW        = (NODES > 1) ? $clog2(NODES) : 1;
   localparam int LW        = (LEVELS > 1) ? $clog2(LEVELS) : 1;
   localparam int ANC_AW    = AW + LW;
   localparam int ANC_DEPTH = 2 ** ANC_AW;
   localparam int CW        = ((LEVELS > DEPTH_W) ? LEVELS : DEPTH_W) + 1;

   localparam logic [3:0] S_CLR   = 4'd0;
   localparam logic [3:0] S_IDLE  = 4'd1;
   localparam logic [3:0] S_RDA   = 4'd2;
   localparam logic [3:0] S_RDB   = 4'd3;
   localparam logic [3:0] S_CHK   = 4'd4;
   localparam logic [3:0] S_FILL  = 4'd5;
   localparam logic [3:0] S_LIFT1 = 4'd6;
   localparam logic [3:0] S_EQ    = 4'd7;
   localparam logic [3:0] S_LIFT2 = 4'd8;
   localparam logic [3:0] S_FIN   = 4'd9;
   localparam logic [3:0] S_LAST  = 4'd10;
   localparam logic [3:0] S_RESP  = 4'd11;

   localparam logic [LW-1:0] K_TOP = LW'(LEVELS - 1);

   // memories
   logic [DEPTH_W-1:0] depth_mem [NODES];
   logic [NODE_W-1:0]  anc_mem   [ANC_DEPTH];

   // control and datapath registers
   logic [3:0]         state_ff, state_in;
   logic [AW-1:0]      clr_ff, clr_in;
   logic [MODE_W-1:0]  mode_ff, mode_in;
   logic [NODE_W-1:0]  a_ff, a_in;
   logic [NODE_W-1:0]  b_ff, b_in;
   logic [DEPTH_W-1:0] da_ff, da_in;
   logic [DEPTH_W-1:0] db_ff, db_in;
   logic [LW-1:0]      k_ff, k_in;
   logic               ta_ff, ta_in;
   logic [NODE_W-1:0]  res_anc_ff, res_anc_in;
   logic [STAT_W-1:0]  res_st_ff, res_st_in;
   logic               rsp_valid_ff, rsp_valid_in;
   lca_rsp_type        rsp_data_ff, rsp_data_in;

   // read ports
   logic [NODE_W-1:0]  dep_node;
   logic [DEPTH_W-1:0] dep_q_ff;
   logic               dep_zero_ff;
   logic               dep_oob_ff;
   logic [DEPTH_W-1:0] dep_val;
   logic               dep_in_range;

   logic [NODE_W-1:0]  pa_node;
   logic [LW-1:0]      pa_lvl;
   logic [NODE_W-1:0]  pb_node;
   logic [NODE_W-1:0]  anc_qa_ff, anc_qb_ff;
   logic               za_ff, zb_ff;
   logic [NODE_W-1:0]  up_a, up_b;

   // write ports
   logic               dep_we;
   logic [AW-1:0]      dep_waddr;
   logic [DEPTH_W-1:0] dep_wdata;
   logic               anc_we;

   // derived values
   logic [NODE_W-1:0]  a_cur, b_cur;
   logic [NODE_W-1:0]  fill_val;
   logic               jump;
   logic               lift_ok;
   logic [CW-1:0]      step;
   logic               real_a;
   logic               placed_a;
   logic               placed_b;

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // depth table: one read, one write per cycle; sentinel and out-of-range handled here
   assign dep_node     = (state_ff == S_RDB) ? b_ff : a_ff;
   assign dep_in_range = (32'(dep_node) < 32'(NODES));

   always_ff @(posedge clock) begin
      dep_zero_ff <= (dep_node == '0);
      dep_oob_ff  <= !dep_in_range;
      if (dep_in_range) begin
         dep_q_ff <= depth_mem[AW'(dep_node)];
      end
      if (dep_we) begin
         depth_mem[dep_waddr] <= dep_wdata;
      end
   end

   assign dep_val = dep_zero_ff ? '0 : (dep_oob_ff ? DEPTH_NONE : dep_q_ff);

   // ancestor table: one write, two reads per cycle; row of node zero reads as zero
   always_ff @(posedge clock) begin
      za_ff     <= (pa_node == '0);
      zb_ff     <= (pb_node == '0);
      anc_qa_ff <= anc_mem[{AW'(pa_node), pa_lvl}];
      anc_qb_ff <= anc_mem[{AW'(pb_node), k_ff}];
      if (anc_we) begin
         anc_mem[{AW'(a_ff), k_ff}] <= fill_val;
      end
   end

   assign up_a = za_ff ? '0 : anc_qa_ff;
   assign up_b = zb_ff ? '0 : anc_qb_ff;

   // level k is the level k-1 ancestor of the node just written at level k-1, read back in the next cycle
   assign fill_val = (k_ff == '0) ? b_ff : up_a;

   // paired lift moves both nodes only when their 2^k ancestors differ
   assign jump = ta_ff && (up_a != up_b);

   always_comb begin
      if (state_ff == S_LIFT2 || state_ff == S_FIN) begin
         a_cur = jump ? up_a : a_ff;
         b_cur = jump ? up_b : b_ff;
      end else begin
         a_cur = ta_ff ? up_a : a_ff;
         b_cur = b_ff;
      end
   end

   // ancestor 2^k above a stays at or below b's depth exactly when da >= db + 2^k
   assign step    = CW'(1) << k_ff;
   assign lift_ok = (CW'(da_ff) >= (CW'(db_ff) + step));

   assign real_a   = (a_ff != '0) && (32'(a_ff) < 32'(NODES));
   assign placed_a = (a_ff != '0) && (da_ff != DEPTH_NONE);
   assign placed_b = (b_ff != '0) && (dep_val != DEPTH_NONE);

   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      mode_in      = mode_ff;
      a_in         = a_ff;
      b_in         = b_ff;
      da_in        = da_ff;
      db_in        = db_ff;
      k_in         = k_ff;
      ta_in        = ta_ff;
      res_anc_in   = res_anc_ff;
      res_st_in    = res_st_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      dep_we       = 1'b0;
      dep_waddr    = AW'(a_ff);
      dep_wdata    = DEPTH_ROOT;
      anc_we       = 1'b0;
      pa_node      = a_cur;
      pa_lvl       = k_ff;
      pb_node      = b_cur;

      unique case (state_ff)
         S_CLR: begin
            dep_we    = 1'b1;
            dep_waddr = clr_ff;
            dep_wdata = (clr_ff == '0) ? '0 : DEPTH_NONE;
            if (clr_ff == AW'(NODES - 1)) begin
               state_in = S_IDLE;
            end else begin
               clr_in = clr_ff + AW'(1);
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               mode_in  = req_data.mode;
               a_in     = req_data.node_a;
               b_in     = req_data.node_b;
               state_in = S_RDA;
            end
         end
         S_RDA: begin
            state_in = S_RDB;
         end
         S_RDB: begin
            da_in    = dep_val;
            state_in = S_CHK;
         end
         S_CHK: begin
            db_in      = dep_val;
            res_anc_in = '0;
            res_st_in  = ST_OK;
            k_in       = '0;
            ta_in      = 1'b0;
            state_in   = S_RESP;
            unique case (mode_ff)
               MODE_ROOT: begin
                  if (!real_a || placed_a) begin
                     res_st_in = ST_REJECT;
                  end else begin
                     dep_we    = 1'b1;
                     dep_wdata = DEPTH_ROOT;
                     b_in      = '0;
                     state_in  = S_FILL;
                  end
               end
               MODE_EDGE: begin
                  if (!real_a || placed_a || !placed_b || dep_val >= DEPTH_FULL) begin
                     res_st_in = ST_REJECT;
                  end else begin
                     dep_we    = 1'b1;
                     dep_wdata = dep_val + DEPTH_W'(1);
                     state_in  = S_FILL;
                  end
               end
               MODE_QUERY: begin
                  if (!placed_a || !placed_b) begin
                     res_st_in = ST_UNPLACED;
                  end else begin
                     // deeper node goes to a
                     if (da_ff < dep_val) begin
                        a_in  = b_ff;
                        b_in  = a_ff;
                        da_in = dep_val;
                        db_in = da_ff;
                     end
                     k_in     = K_TOP;
                     state_in = S_LIFT1;
                  end
               end
               default: begin
                  res_st_in = ST_OK;
               end
            endcase
         end
         S_FILL: begin
            anc_we  = 1'b1;
            pa_node = fill_val;
            if (k_ff == K_TOP) begin
               state_in = S_RESP;
            end else begin
               k_in = k_ff + LW'(1);
            end
         end
         S_LIFT1: begin
            a_in  = a_cur;
            ta_in = lift_ok;
            if (lift_ok) begin
               da_in = DEPTH_W'(CW'(da_ff) - step);
            end
            if (k_ff == '0) begin
               state_in = S_EQ;
            end else begin
               k_in = k_ff - LW'(1);
            end
         end
         S_EQ: begin
            a_in  = a_cur;
            ta_in = 1'b0;
            if (a_cur == b_ff) begin
               res_anc_in = a_cur;
               state_in   = S_RESP;
            end else begin
               k_in     = K_TOP;
               state_in = S_LIFT2;
            end
         end
         S_LIFT2: begin
            a_in  = a_cur;
            b_in  = b_cur;
            ta_in = 1'b1;
            if (k_ff == '0) begin
               state_in = S_FIN;
            end else begin
               k_in = k_ff - LW'(1);
            end
         end
         S_FIN: begin
            a_in     = a_cur;
            b_in     = b_cur;
            pa_lvl   = '0;
            state_in = S_LAST;
         end
         S_LAST: begin
            res_anc_in = up_a;
            state_in   = S_RESP;
         end
         S_RESP: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in         = 1'b1;
               rsp_data_in.ancestor = res_anc_ff;
               rsp_data_in.status   = res_st_ff;
               state_in             = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff     <= mode_in;
      a_ff        <= a_in;
      b_ff        <= b_in;
      da_ff       <= da_in;
      db_ff       <= db_in;
      k_ff        <= k_in;
      ta_ff       <= ta_in;
      res_anc_ff  <= res_anc_in;
      res_st_ff   <= res_st_in;
      rsp_data_ff <= rsp_data_in;
   end

   // one transaction at a time: busy right after an accept
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request accepted while previous transaction in flight");

   // depth lift never moves the deeper node above the other one
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_LIFT1) |-> (da_ff >= db_ff))
      else $error("depth lift overshot");

   // paired lift only runs on distinct nodes
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_LIFT2) |-> (a_ff != b_ff))
      else $error("paired lift on equal nodes");

   // a rejected or failed transaction never reports an ancestor
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status != ST_OK) |-> (rsp_data.ancestor == '0))
      else $error("nonzero ancestor with error status");

endmodule

`default_nettype wire
